// ===== hw/rtl/edbp_pkg.sv =====
// ----------------------------------------------------------------------------
// EDID base block parser package
// Shared constants, the status codes, the parse-to-trim result record and helpers.
// ----------------------------------------------------------------------------
package edbp_pkg;

  localparam int EdidLen    = 128;
  localparam int HeaderLen  = 8;
  localparam int DescBase   = 54;
  localparam int DescStride = 18;
  localparam int DescCount  = 4;
  localparam int DescEnd    = DescBase + DescCount * DescStride;
  localparam int NameFirst  = 5;
  localparam int NameMax    = 13;
  localparam int NameBits   = NameMax * 8;

  localparam logic [7:0] NameTag  = 8'hFC;
  localparam logic [7:0] NameEnd  = 8'h0A;
  localparam logic [7:0] HdrOuter = 8'h00;
  localparam logic [7:0] HdrInner = 8'hFF;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_SHORT      = 2'd1,
    STATUS_BAD_HEADER = 2'd2,
    STATUS_NO_TIMING  = 2'd3
  } status_t;

  typedef struct packed {
    status_t                status;
    logic [11:0]            width;
    logic [11:0]            height;
    logic                   found;
    logic [3:0]             count;
    logic [NameBits-1:0]    name;
  } snap_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
  endfunction

  function automatic logic [7:0] header_byte(input logic [2:0] idx);
    return ((idx == 3'd0) || (idx == 3'd7)) ? HdrOuter : HdrInner;
  endfunction

endpackage

// ===== hw/rtl/edbp_in_reg.sv =====
// ----------------------------------------------------------------------------
// EDID parser input register
// Holds one incoming item so the parse stage works from registered data.
// ----------------------------------------------------------------------------
module edbp_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       data_valid,
  output logic       data_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       byte_valid,
  input  logic       byte_ready,
  output logic [7:0] byte_data,
  output logic       byte_last
);

  assign data_ready = !byte_valid || byte_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (data_ready) begin
      byte_valid <= data_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (data_ready && data_valid) begin
      byte_data <= data_byte;
      byte_last <= last_byte;
    end
  end

endmodule

// ===== hw/rtl/edbp_parse.sv =====
// ----------------------------------------------------------------------------
// EDID parser byte stage
// Updates the per-image state for each byte and captures a record of the
// finished image when the last byte is taken.
// ----------------------------------------------------------------------------
module edbp_parse (
  input  logic            clk,
  input  logic            rst,
  input  logic            byte_valid,
  output logic            byte_ready,
  input  logic [7:0]      byte_data,
  input  logic            byte_last,
  output logic            snap_valid,
  input  logic            snap_ready,
  output edbp_pkg::snap_t snap
);
  import edbp_pkg::*;

  logic [7:0]  byte_position, byte_position_next;
  logic        header_good, header_good_next;
  logic        clock_nonzero, clock_nonzero_next;
  logic [11:0] horiz_active, horiz_active_next;
  logic [11:0] vert_active, vert_active_next;
  logic        tag_prefix_good, tag_prefix_good_next;
  logic        descriptor_found, descriptor_found_next;
  logic        name_stopped, name_stopped_next;
  logic [4:0]  desc_offset, desc_offset_next;
  logic [3:0]  name_count, name_count_next;
  logic [7:0]  name_store [NameMax];
  logic        name_write;
  logic [NameBits-1:0] name_flat;
  logic        take;
  logic        take_last;
  status_t     status_next;

  assign byte_ready = !byte_valid || !byte_last || !snap_valid || snap_ready;
  assign take       = byte_valid && byte_ready;
  assign take_last  = take && byte_last;

  always_comb begin
    byte_position_next    = byte_position;
    header_good_next      = header_good;
    clock_nonzero_next    = clock_nonzero;
    horiz_active_next     = horiz_active;
    vert_active_next      = vert_active;
    tag_prefix_good_next  = tag_prefix_good;
    descriptor_found_next = descriptor_found;
    name_stopped_next     = name_stopped;
    desc_offset_next      = desc_offset;
    name_count_next       = name_count;
    name_write            = 1'b0;

    if (byte_position < 8'(EdidLen)) begin
      byte_position_next = byte_position + 8'd1;

      if (byte_position < 8'(HeaderLen) && byte_data != header_byte(byte_position[2:0])) begin
        header_good_next = 1'b0;
      end
      if ((byte_position == 8'(DescBase) || byte_position == 8'(DescBase + 1)) &&
          byte_data != 8'd0) begin
        clock_nonzero_next = 1'b1;
      end
      if (byte_position == 8'(DescBase + 2)) begin
        horiz_active_next[7:0] = byte_data;
      end
      if (byte_position == 8'(DescBase + 4)) begin
        horiz_active_next[11:8] = byte_data[7:4];
      end
      if (byte_position == 8'(DescBase + 5)) begin
        vert_active_next[7:0] = byte_data;
      end
      if (byte_position == 8'(DescBase + 7)) begin
        vert_active_next[11:8] = byte_data[7:4];
      end

      if (byte_position == 8'(DescBase - 1)) begin
        desc_offset_next = 5'd0;
      end else if (byte_position >= 8'(DescBase) && byte_position < 8'(DescEnd)) begin
        desc_offset_next = (desc_offset == 5'(DescStride - 1)) ? 5'd0 : desc_offset + 5'd1;

        if (!descriptor_found) begin
          if (desc_offset == 5'd0) begin
            tag_prefix_good_next = (byte_data == 8'd0);
          end else if (desc_offset < 5'd3) begin
            tag_prefix_good_next = tag_prefix_good && (byte_data == 8'd0);
          end else if (desc_offset == 5'd3 && tag_prefix_good && byte_data == NameTag) begin
            descriptor_found_next = 1'b1;
            name_stopped_next     = 1'b0;
            name_count_next       = 4'd0;
          end
        end else if (!name_stopped && desc_offset >= 5'(NameFirst)) begin
          if (byte_data == NameEnd || byte_data == 8'd0) begin
            name_stopped_next = 1'b1;
          end else if (name_count < 4'(NameMax)) begin
            name_write      = 1'b1;
            name_count_next = name_count + 4'd1;
          end
          if (desc_offset == 5'(DescStride - 1)) begin
            name_stopped_next = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NameMax; i++) begin
      name_flat[8*i +: 8] = (name_write && name_count == 4'(i)) ? byte_data : name_store[i];
    end
  end

  always_comb begin
    priority if (byte_position_next < 8'(EdidLen)) begin
      status_next = STATUS_SHORT;
    end else if (!header_good_next) begin
      status_next = STATUS_BAD_HEADER;
    end else if (clock_nonzero_next && horiz_active_next != 12'd0 &&
                 vert_active_next != 12'd0) begin
      status_next = STATUS_OK;
    end else begin
      status_next = STATUS_NO_TIMING;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || take_last) begin
      byte_position    <= 8'd0;
      header_good      <= 1'b1;
      clock_nonzero    <= 1'b0;
      horiz_active     <= 12'd0;
      vert_active      <= 12'd0;
      tag_prefix_good  <= 1'b1;
      descriptor_found <= 1'b0;
      name_stopped     <= 1'b0;
      desc_offset      <= 5'd0;
      name_count       <= 4'd0;
    end else if (take) begin
      byte_position    <= byte_position_next;
      header_good      <= header_good_next;
      clock_nonzero    <= clock_nonzero_next;
      horiz_active     <= horiz_active_next;
      vert_active      <= vert_active_next;
      tag_prefix_good  <= tag_prefix_good_next;
      descriptor_found <= descriptor_found_next;
      name_stopped     <= name_stopped_next;
      desc_offset      <= desc_offset_next;
      name_count       <= name_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && name_write) begin
      name_store[name_count] <= byte_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (take_last) begin
      snap_valid <= 1'b1;
    end else if (snap_ready) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_last) begin
      snap.status <= status_next;
      snap.width  <= (status_next == STATUS_OK) ? horiz_active_next : 12'd0;
      snap.height <= (status_next == STATUS_OK) ? vert_active_next : 12'd0;
      snap.found  <= descriptor_found_next &&
                     (status_next == STATUS_OK || status_next == STATUS_NO_TIMING);
      snap.count  <= name_count_next;
      snap.name   <= name_flat;
    end
  end

  assert property (@(posedge clk) disable iff (rst) name_count <= 4'(NameMax))
    else $error("name count exceeds the name store");
  assert property (@(posedge clk) disable iff (rst) take_last |=> byte_position == 8'd0)
    else $error("state not cleared after the last item of an image");
  assert property (@(posedge clk) disable iff (rst)
    snap_valid && snap.status != STATUS_OK |-> snap.width == 12'd0 && snap.height == 12'd0)
    else $error("sizes reported without valid timing");

endmodule

// ===== hw/rtl/edbp_trim.sv =====
// ----------------------------------------------------------------------------
// EDID parser name trim and result register
// Removes leading and trailing blanks from the collected name and registers
// the finished result.
// ----------------------------------------------------------------------------
module edbp_trim (
  input  logic            clk,
  input  logic            rst,
  input  logic            snap_valid,
  output logic            snap_ready,
  input  edbp_pkg::snap_t snap,
  output logic            result_valid,
  input  logic            result_ready,
  output logic [1:0]      status,
  output logic [11:0]     active_width,
  output logic [11:0]     active_height,
  output logic            name_found,
  output logic [3:0]      name_length,
  output logic [63:0]     name_head,
  output logic [39:0]     name_tail
);
  import edbp_pkg::*;

  logic [3:0]          first_char;
  logic [3:0]          end_char;
  logic                any_char;
  logic [3:0]          trim_length;
  logic [NameBits-1:0] shifted;
  logic [NameBits-1:0] trimmed;
  logic                load;

  assign snap_ready = !result_valid || result_ready;
  assign load       = snap_valid && snap_ready;

  always_comb begin
    first_char = snap.count;
    end_char   = 4'd0;
    any_char   = 1'b0;
    for (int i = NameMax - 1; i >= 0; i--) begin
      if (4'(i) < snap.count && !is_blank(snap.name[8*i +: 8])) begin
        first_char = 4'(i);
      end
    end
    for (int i = 0; i < NameMax; i++) begin
      if (4'(i) < snap.count && !is_blank(snap.name[8*i +: 8])) begin
        end_char = 4'(i + 1);
        any_char = 1'b1;
      end
    end
    trim_length = (any_char && snap.found) ? end_char - first_char : 4'd0;
    shifted     = snap.name >> {first_char, 3'b000};
    for (int j = 0; j < NameMax; j++) begin
      trimmed[8*j +: 8] = (4'(j) < trim_length) ? shifted[8*j +: 8] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (snap_ready) begin
      result_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status        <= snap.status;
      active_width  <= snap.width;
      active_height <= snap.height;
      name_found    <= snap.found;
      name_length   <= trim_length;
      name_head     <= trimmed[63:0];
      name_tail     <= trimmed[NameBits-1:64];
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    result_valid && name_length != 4'd0 |-> name_found)
    else $error("name length reported without a name descriptor");
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == STATUS_SHORT || status == STATUS_BAD_HEADER) |-> !name_found)
    else $error("name reported for a short image or a bad header");

endmodule

// ===== hw/rtl/edid_base_block_parser_unit.sv =====
// ----------------------------------------------------------------------------
// EDID base block parser
// Parses a byte stream of an EDID base block and reports status, native
// size and the trimmed monitor name.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle, back to back, unless the result side
// stalls, and produces one result item for each byte marked last. A byte
// passes an input register, the parse stage and the result register; the
// parse stage does a single per-byte state update, and back-pressure from
// the result side stalls it only on a byte marked last. After each result
// all image state is cleared and the next byte starts a new image.
module edid_base_block_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  status,
  output logic [11:0] active_width,
  output logic [11:0] active_height,
  output logic        name_found,
  output logic [3:0]  name_length,
  output logic [63:0] name_head,
  output logic [39:0] name_tail
);
  import edbp_pkg::*;

  logic       byte_valid;
  logic       byte_ready;
  logic [7:0] byte_data;
  logic       byte_last;
  logic       snap_valid;
  logic       snap_ready;
  snap_t      snap;

  edbp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_ready (data_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .byte_last  (byte_last)
  );

  edbp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .byte_last  (byte_last),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  edbp_trim u_trim (
    .clk           (clk),
    .rst           (rst),
    .snap_valid    (snap_valid),
    .snap_ready    (snap_ready),
    .snap          (snap),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .status        (status),
    .active_width  (active_width),
    .active_height (active_height),
    .name_found    (name_found),
    .name_length   (name_length),
    .name_head     (name_head),
    .name_tail     (name_tail)
  );

endmodule

// ===== dv/tb_edid_base_block_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EDID base block parser testbench
// Streams directed and random EDID images into the parser byte by byte and
// checks every summary item against a predictor that tracks the parse
// state. Both handshakes idle and stall in several phases. A long receiver
// hold-off fills the block, and some images wait for the summaries still
// outstanding.
// ----------------------------------------------------------------------------
module tb_edid_base_block_parser_unit;
  import edbp_pkg::*;

  localparam int IdleLimit   = 4000;
  localparam int HoldCycles  = 400;
  localparam int SettleTicks = 20;
  localparam int ImageMax    = 140;

  typedef struct {
    logic [7:0] value;
    logic       last;
    int         tx_gap;
    int         rx_gap;
    bit         drain_first;
    bit         hold_rx;
  } edid_byte_t;

  typedef struct {
    status_t     status;
    logic [11:0] width;
    logic [11:0] height;
    logic        found;
    logic [3:0]  length;
    logic [63:0] head;
    logic [39:0] tail;
  } edid_summary_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        data_valid   = 1'b0;
  logic        data_ready;
  logic [7:0]  data_byte    = 8'h00;
  logic        last_byte    = 1'b0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [1:0]  status;
  logic [11:0] active_width;
  logic [11:0] active_height;
  logic        name_found;
  logic [3:0]  name_length;
  logic [63:0] name_head;
  logic [39:0] name_tail;

  edid_byte_t    edid_stream[$];
  edid_summary_t due_summaries[$];
  logic [7:0]    edid_img [ImageMax];

  int tx_gap_pct [4] = '{0, 58, 0, 11};
  int rx_gap_pct [4] = '{0, 0, 58, 11};

  int   rx_stall_pct = 0;
  int   hold_seq     = 0;
  int   hold_seen    = 0;
  int   hold_left    = 0;
  logic in_fire      = 1'b0;
  int   idle_cycles  = 0;
  int   mismatches   = 0;

  int         byte_pos;
  logic       hdr_ok;
  logic       clk_nz;
  logic [11:0] h_act;
  logic [11:0] v_act;
  logic       prefix_ok;
  logic       desc_hit;
  logic       name_done;
  int         name_cnt;
  logic [7:0] name_buf [NameMax];

  edid_base_block_parser_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .data_valid    (data_valid),
    .data_ready    (data_ready),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .status        (status),
    .active_width  (active_width),
    .active_height (active_height),
    .name_found    (name_found),
    .name_length   (name_length),
    .name_head     (name_head),
    .name_tail     (name_tail)
  );

  always #10 clk = ~clk;

  function automatic logic is_pad_char(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
  endfunction

  task automatic clear_parser();
    byte_pos  = 0;
    hdr_ok    = 1'b1;
    clk_nz    = 1'b0;
    h_act     = '0;
    v_act     = '0;
    prefix_ok = 1'b1;
    desc_hit  = 1'b0;
    name_done = 1'b0;
    name_cnt  = 0;
    for (int i = 0; i < NameMax; i++) name_buf[i] = 8'h00;
  endtask

  task automatic parse_edid_byte(input logic [7:0] b, input logic last);
    int            r;
    int            s;
    int            e;
    logic [7:0]    hdr;
    edid_summary_t res;
    if (byte_pos < EdidLen) begin
      hdr = (byte_pos == 0 || byte_pos == HeaderLen - 1) ? 8'h00 : 8'hFF;
      if (byte_pos < HeaderLen && b != hdr) hdr_ok = 1'b0;
      if ((byte_pos == DescBase || byte_pos == DescBase + 1) && b != 8'h00) clk_nz = 1'b1;
      if (byte_pos == DescBase + 2) h_act[7:0] = b;
      if (byte_pos == DescBase + 4) h_act[11:8] = b[7:4];
      if (byte_pos == DescBase + 5) v_act[7:0] = b;
      if (byte_pos == DescBase + 7) v_act[11:8] = b[7:4];
      if (byte_pos >= DescBase && byte_pos < DescEnd) begin
        r = (byte_pos - DescBase) % DescStride;
        if (!desc_hit) begin
          if (r == 0) begin
            prefix_ok = (b == 8'h00);
          end else if (r < 3) begin
            prefix_ok = prefix_ok && (b == 8'h00);
          end else if (r == 3 && prefix_ok && b == NameTag) begin
            desc_hit  = 1'b1;
            name_done = 1'b0;
            name_cnt  = 0;
          end
        end else if (!name_done && r >= NameFirst) begin
          if (b == NameEnd || b == 8'h00) begin
            name_done = 1'b1;
          end else if (name_cnt < NameMax) begin
            name_buf[name_cnt] = b;
            name_cnt++;
          end
          if (r == DescStride - 1) name_done = 1'b1;
        end
      end
      byte_pos++;
    end
    if (last) begin
      if (byte_pos < EdidLen) res.status = STATUS_SHORT;
      else if (!hdr_ok) res.status = STATUS_BAD_HEADER;
      else if (clk_nz && h_act != 0 && v_act != 0) res.status = STATUS_OK;
      else res.status = STATUS_NO_TIMING;
      res.width  = (res.status == STATUS_OK) ? h_act : 12'd0;
      res.height = (res.status == STATUS_OK) ? v_act : 12'd0;
      res.found  = 1'b0;
      res.length = 4'd0;
      res.head   = '0;
      res.tail   = '0;
      if ((res.status == STATUS_OK || res.status == STATUS_NO_TIMING) && desc_hit) begin
        res.found = 1'b1;
        s = 0;
        e = name_cnt;
        while (s < e && is_pad_char(name_buf[s])) s++;
        while (e > s && is_pad_char(name_buf[e - 1])) e--;
        res.length = 4'(e - s);
        for (int k = 0; k < e - s; k++) begin
          if (k < 8) res.head[8*k +: 8] = name_buf[s + k];
          else res.tail[8*(k-8) +: 8] = name_buf[s + k];
        end
      end
      due_summaries.insert(due_summaries.size(), res);
      clear_parser();
    end
  endtask

  task automatic note_miss(input string what, input logic [63:0] want, input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  // Image building: header, a detailed timing with the given sizes and
  // descriptors that never carry the name tag.
  task automatic make_base(input logic [11:0] w, input logic [11:0] h);
    int b;
    for (int i = 0; i < ImageMax; i++) edid_img[i] = 8'($urandom_range(255));
    for (int i = 0; i < HeaderLen; i++)
      edid_img[i] = (i == 0 || i == HeaderLen - 1) ? 8'h00 : 8'hFF;
    edid_img[DescBase]     = 8'($urandom_range(1, 255));
    edid_img[DescBase + 2] = w[7:0];
    edid_img[DescBase + 4] = {w[11:8], edid_img[DescBase + 4][3:0]};
    edid_img[DescBase + 5] = h[7:0];
    edid_img[DescBase + 7] = {h[11:8], edid_img[DescBase + 7][3:0]};
    for (int slot = 1; slot < DescCount; slot++) begin
      b = DescBase + slot * DescStride;
      if ($urandom_range(1) == 1) begin
        edid_img[b]     = 8'h00;
        edid_img[b + 1] = 8'h00;
        edid_img[b + 2] = 8'h00;
        edid_img[b + 3] = 8'hF0 | 8'($urandom_range(11));
      end
    end
  endtask

  task automatic put_name(input int slot, input string txt, input logic [7:0] pad);
    int b;
    b = DescBase + slot * DescStride;
    edid_img[b]     = 8'h00;
    edid_img[b + 1] = 8'h00;
    edid_img[b + 2] = 8'h00;
    edid_img[b + 3] = NameTag;
    for (int k = 0; k < NameMax; k++)
      edid_img[b + NameFirst + k] = (k < txt.len()) ? txt[k] : pad;
  endtask

  task automatic rand_name(input int slot);
    int b;
    int pick;
    put_name(slot, "", 8'h00);
    b = DescBase + slot * DescStride;
    for (int k = 0; k < NameMax; k++) begin
      pick = $urandom_range(99);
      if (pick < 60) edid_img[b + NameFirst + k] = 8'($urandom_range(8'h21, 8'h7E));
      else if (pick < 66) edid_img[b + NameFirst + k] = 8'h20;
      else if (pick < 71) edid_img[b + NameFirst + k] = 8'h09;
      else if (pick < 76) edid_img[b + NameFirst + k] = 8'h0D;
      else if (pick < 82) edid_img[b + NameFirst + k] = NameEnd;
      else if (pick < 85) edid_img[b + NameFirst + k] = 8'h00;
      else edid_img[b + NameFirst + k] = 8'($urandom_range(255));
    end
  endtask

  task automatic queue_image(input int len, input int phase, input bit drain, input bit hold);
    edid_byte_t it;
    for (int i = 0; i < len; i++) begin
      it.value       = edid_img[i];
      it.last        = (i == len - 1);
      it.tx_gap      = tx_gap_pct[phase];
      it.rx_gap      = rx_gap_pct[phase];
      it.drain_first = drain && (i == 0);
      it.hold_rx     = hold && (i == 0);
      edid_stream.insert(edid_stream.size(), it);
    end
  endtask

  function automatic logic [11:0] rand_size();
    if ($urandom_range(15) == 0) return 12'd0;
    if ($urandom_range(15) == 0) return 12'hFFF;
    return 12'($urandom_range(1, 4095));
  endfunction

  task automatic random_image(input int phase, input bit drain, output int len);
    int kind;
    int slot;
    int b;
    int hi;
    kind = $urandom_range(99);
    make_base(rand_size(), rand_size());
    if ($urandom_range(9) == 0) begin
      edid_img[DescBase]     = 8'h00;
      edid_img[DescBase + 1] = ($urandom_range(1) == 1) ? 8'h00 : 8'($urandom_range(255));
    end
    slot = -1;
    case ($urandom_range(9))
      0: slot = -1;
      1: slot = 0;
      default: slot = $urandom_range(1, DescCount - 1);
    endcase
    if (slot >= 0) begin
      rand_name(slot);
      if (slot < DescCount - 1 && $urandom_range(3) == 0)
        rand_name($urandom_range(slot + 1, DescCount - 1));
      if (slot > 1 && $urandom_range(2) == 0) begin
        b = DescBase + (slot - 1) * DescStride;
        edid_img[b]     = 8'h00;
        edid_img[b + 1] = 8'h00;
        edid_img[b + 2] = 8'h00;
        edid_img[b + 3] = NameTag;
        edid_img[b + $urandom_range(2)] = 8'($urandom_range(1, 255));
      end
    end
    len = EdidLen;
    if ($urandom_range(4) == 0) len = EdidLen + $urandom_range(1, ImageMax - EdidLen);
    if (kind < 12) begin
      hi = $urandom_range(HeaderLen - 1);
      edid_img[hi] = edid_img[hi] ^ 8'($urandom_range(1, 255));
    end else if (kind < 27) begin
      len = $urandom_range(1, EdidLen - 1);
    end else if (kind < 35) begin
      for (int i = 0; i < ImageMax; i++) edid_img[i] = 8'($urandom_range(255));
      len = $urandom_range(1, ImageMax);
    end
    queue_image(len, phase, drain, 1'b0);
  endtask

  // A run of one-byte images that fills the block while the receiver holds off.
  task automatic queue_burst();
    for (int i = 0; i < 30; i++) begin
      edid_img[0] = 8'($urandom_range(255));
      queue_image(1, 0, 1'b0, i == 0);
    end
  endtask

  always @(negedge clk) begin : drive_bytes
    edid_byte_t nxt;
    logic       go;
    if (!rst && (!data_valid || in_fire)) begin
      go = 1'b0;
      if (edid_stream.size() > 0) begin
        nxt = edid_stream[0];
        if (nxt.drain_first && due_summaries.size() > 0) go = 1'b0;
        else go = ($urandom_range(99) >= nxt.tx_gap);
      end
      if (go) begin
        void'(edid_stream.pop_front());
        data_valid   <= 1'b1;
        data_byte    <= nxt.value;
        last_byte    <= nxt.last;
        rx_stall_pct <= nxt.rx_gap;
        if (nxt.hold_rx) hold_seq <= hold_seq + 1;
      end else begin
        data_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : take_results
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      result_ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_seen != hold_seq) begin
      hold_seen    <= hold_seq;
      hold_left    <= HoldCycles;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin : watch_ports
    edid_summary_t want;
    if (rst) begin
      in_fire <= 1'b0;
      clear_parser();
    end else begin
      in_fire <= data_valid && data_ready;
      if (result_valid && result_ready) begin
        if (due_summaries.size() == 0) begin
          note_miss("unrequested summary, status", 64'd0, 64'(status));
        end else begin
          want = due_summaries.pop_front();
          if (status !== want.status) note_miss("status", 64'(want.status), 64'(status));
          if (active_width !== want.width)
            note_miss("active_width", 64'(want.width), 64'(active_width));
          if (active_height !== want.height)
            note_miss("active_height", 64'(want.height), 64'(active_height));
          if (name_found !== want.found)
            note_miss("name_found", 64'(want.found), 64'(name_found));
          if (name_length !== want.length)
            note_miss("name_length", 64'(want.length), 64'(name_length));
          if (name_head !== want.head) note_miss("name_head", want.head, name_head);
          if (name_tail !== want.tail)
            note_miss("name_tail", 64'(want.tail), 64'(name_tail));
        end
      end
      if (data_valid && data_ready) parse_edid_byte(data_byte, last_byte);
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (data_valid && data_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no handshake for %0d cycles", $realtime, IdleLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin : run_images
    int n_bytes;
    int n_imgs;
    int len;
    clear_parser();

    edid_img[0] = 8'hFF;
    queue_image(1, 0, 1'b0, 1'b0);
    edid_img[0] = 8'h00;
    queue_image(1, 1, 1'b0, 1'b0);
    make_base(12'd1920, 12'd1080);
    put_name(3, "MONITOR\n", 8'h20);
    queue_image(EdidLen - 1, 2, 1'b0, 1'b0);
    make_base(12'd1920, 12'd1080);
    put_name(3, "MONITOR\n", 8'h20);
    queue_image(EdidLen, 3, 1'b0, 1'b0);
    make_base(12'hFFF, 12'hFFF);
    put_name(1, "ABCDEFGHIJKLM", 8'h20);
    queue_image(EdidLen, 0, 1'b0, 1'b0);
    make_base(12'd1, 12'd1);
    put_name(2, "HDR", NameEnd);
    edid_img[HeaderLen - 1] = 8'h01;
    queue_image(EdidLen, 1, 1'b0, 1'b0);
    make_base(12'd800, 12'd600);
    edid_img[DescBase]     = 8'h00;
    edid_img[DescBase + 1] = 8'h00;
    put_name(2, "NOCLK", NameEnd);
    queue_image(EdidLen, 2, 1'b0, 1'b0);
    make_base(12'd0, 12'd600);
    put_name(1, "\011  HI \015 \nXY", 8'h20);
    queue_image(EdidLen, 3, 1'b0, 1'b0);
    make_base(12'd640, 12'd0);
    put_name(1, "   \011\015   ", 8'h20);
    queue_image(EdidLen, 0, 1'b0, 1'b0);
    make_base(12'd640, 12'd480);
    put_name(2, "", 8'h00);
    queue_image(EdidLen, 1, 1'b1, 1'b0);
    make_base(12'd1024, 12'd768);
    put_name(0, "SLOTZERO", NameEnd);
    queue_image(EdidLen, 2, 1'b0, 1'b0);
    make_base(12'd1024, 12'd768);
    put_name(1, "FIRST", NameEnd);
    put_name(2, "SECOND", NameEnd);
    queue_image(EdidLen, 3, 1'b0, 1'b0);
    make_base(12'd1280, 12'd1024);
    put_name(1, "FAKE", NameEnd);
    edid_img[DescBase + DescStride + 2] = 8'h01;
    put_name(3, "REAL", NameEnd);
    queue_image(EdidLen, 0, 1'b0, 1'b0);
    make_base(12'd2560, 12'd1440);
    put_name(2, "AB\nCD", 8'h20);
    queue_image(ImageMax, 1, 1'b0, 1'b0);
    edid_img[0] = 8'h5A;
    queue_image(1, 2, 1'b0, 1'b0);
    make_base(12'd3840, 12'd2160);
    queue_image(EdidLen, 3, 1'b0, 1'b0);
    make_base(12'd1600, 12'd900);
    put_name(1, "\377\200\177\041", NameEnd);
    queue_image(EdidLen, 0, 1'b0, 1'b0);

    n_bytes = 0;
    n_imgs  = 0;
    while (n_bytes < 500) begin
      if (n_imgs == 1 || n_imgs == 3) queue_burst();
      random_image($urandom_range(3), (n_imgs % 7) == 0, len);
      n_bytes += len;
      n_imgs++;
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (edid_stream.size() != 0 || data_valid || due_summaries.size() != 0);
    repeat (SettleTicks) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
